### rtl/stsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package stsi_pkg;

    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W = 4;
    localparam int FILL_W = 5;
    localparam int TABLE_DEPTH_DEF = 16;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_FULL     = 2'd2
    } t_status;

endpackage
`default_nettype wire

### rtl/stsi_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface stsi_in_if;
    import stsi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface stsi_out_if;
    import stsi_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] filled_after;

    modport source (output valid, output status, output position, output filled_after,
                    input ready);
    modport sink (input valid, input status, input position, input filled_after,
                  output ready);
endinterface
`default_nettype wire

### rtl/stsi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module stsi_ram #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire                               i_clk,
    input  wire                               i_wr_en,
    input  wire  [AW-1:0]                     i_wr_addr,
    input  wire  signed [stsi_pkg::VALUE_W-1:0] i_wr_data,
    input  wire                               i_rd_en,
    input  wire  [AW-1:0]                     i_rd_addr,
    output logic signed [stsi_pkg::VALUE_W-1:0] o_rd_data
);
    import stsi_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/sorted_table_search_insert_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The scan stops at a matching entry, or at a larger entry in a full table; otherwise it runs
// over all n filled entries, n = fill count, at most TABLE_DEPTH. Each entry is handled by a
// memory read, then a compare and write back. One transaction is in flight at a time; the
// next is accepted only once the unit is idle and its registered result has left or leaves
// in the same cycle.
// Reset (synchronous, active low) empties the table; memory contents are not cleared.
module sorted_table_search_insert_unit #(
    parameter int TABLE_DEPTH = stsi_pkg::TABLE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    stsi_in_if.sink     i_in,
    stsi_out_if.source  o_out
);
    import stsi_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;

    logic [1:0]                r_state, n_state;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic signed [VALUE_W-1:0] r_carry, n_carry;
    logic [CW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic                      r_shift, n_shift;
    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic [POS_W-1:0]          r_out_pos, n_out_pos;
    logic [FILL_W-1:0]         r_out_fill, n_out_fill;

    logic                      wr_en;
    logic signed [VALUE_W-1:0] wr_data;
    logic                      rd_en;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      full;
    logic                      in_acc;
    logic                      done;
    t_status                   d_status;
    logic [CW-1:0]             d_pos;
    logic [CW-1:0]             d_cnt;

    stsi_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign full = (r_cnt == CW'(TABLE_DEPTH));
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.position = r_out_pos;
    assign o_out.filled_after = r_out_fill;

    always_comb begin
        n_state = r_state;
        n_val = r_val;
        n_carry = r_carry;
        n_idx = r_idx;
        n_pos = r_pos;
        n_shift = r_shift;
        wr_en = 1'b0;
        wr_data = r_carry;
        rd_en = 1'b0;
        done = 1'b0;
        d_status = STATUS_FOUND;
        d_pos = r_idx;
        d_cnt = r_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val = i_in.value;
                    n_idx = '0;
                    n_shift = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_idx == r_cnt) begin
                    if (r_shift) begin
                        wr_en = 1'b1;
                        done = 1'b1;
                        d_status = STATUS_INSERTED;
                        d_pos = r_pos;
                        d_cnt = r_cnt + 1'b1;
                    end else if (full) begin
                        done = 1'b1;
                        d_status = STATUS_FULL;
                        d_pos = '0;
                    end else begin
                        wr_en = 1'b1;
                        wr_data = r_val;
                        done = 1'b1;
                        d_status = STATUS_INSERTED;
                        d_pos = r_idx;
                        d_cnt = r_cnt + 1'b1;
                    end
                end else begin
                    rd_en = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_shift) begin
                    wr_en = 1'b1;
                    n_carry = rd_data;
                    n_idx = r_idx + 1'b1;
                    n_state = S_RD;
                end else if (rd_data == r_val) begin
                    done = 1'b1;
                    d_status = STATUS_FOUND;
                    d_pos = r_idx;
                end else if (rd_data > r_val) begin
                    if (full) begin
                        done = 1'b1;
                        d_status = STATUS_FULL;
                        d_pos = '0;
                    end else begin
                        wr_en = 1'b1;
                        wr_data = r_val;
                        n_pos = r_idx;
                        n_shift = 1'b1;
                        n_carry = rd_data;
                        n_idx = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (done) begin
            n_state = S_IDLE;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_pos = r_out_pos;
        n_out_fill = r_out_fill;
        if (done) begin
            n_cnt = d_cnt;
            n_out_valid = 1'b1;
            n_out_status = d_status;
            n_out_pos = POS_W'(d_pos);
            n_out_fill = FILL_W'(d_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_shift <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_shift <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_carry <= n_carry;
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos <= n_out_pos;
        r_out_fill <= n_out_fill;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_idx <= r_cnt) && !full)
        else $error("write outside filled range or into full table");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_cnt != $past(r_cnt))) |->
            (r_cnt == $past(r_cnt) + 1'b1) && $past(done))
        else $error("fill count changed other than by one insertion");

    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RD) || ($past(r_state) == S_CMP))
        else $error("result raised outside a scan");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("transaction accepted during scan");

endmodule
`default_nettype wire

### test/sorted_table_search_insert_unit_test.sv
`timescale 1ns / 1ps
module sorted_table_search_insert_unit_test;
    import stsi_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RANDOM_ITEMS = 1550;
    localparam int TAIL_ITEMS = 150;
    localparam int HOLD_OFF_START = 300;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH_DEF + 8;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] filled_after;
    } t_table_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stsi_in_if  in_bus ();
    stsi_out_if out_bus ();

    sorted_table_search_insert_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // table mirror
    logic signed [VALUE_W-1:0] mirror_entries [TABLE_DEPTH_DEF];
    int                        mirror_count = 0;

    logic signed [VALUE_W-1:0] pending_values [$];
    t_table_result             awaited_results [$];

    int  total_items = 0;
    int  accepted_items = 0;
    int  checked_results = 0;
    int  mismatch_count = 0;
    int  found_seen = 0;
    int  inserted_seen = 0;
    int  full_seen = 0;
    bit  in_taken = 1'b0;
    bit  tail_part = 1'b0;
    bit  hold_off = 1'b0;
    int  tx_gap_left = 0;
    int  tx_calm_left = 0;
    int  rx_gap_left = 0;
    int  rx_calm_left = 0;

    function automatic t_table_result search_or_insert(logic signed [VALUE_W-1:0] key);
        int            scan;
        int            slot;
        t_table_result res;
        scan = 0;
        while (scan < mirror_count && mirror_entries[scan] != key) scan++;
        if (scan < mirror_count) begin
            res = '{STATUS_FOUND, POS_W'(scan), FILL_W'(mirror_count)};
        end else if (mirror_count >= TABLE_DEPTH_DEF) begin
            res = '{STATUS_FULL, '0, FILL_W'(mirror_count)};
        end else begin
            slot = 0;
            while (slot < mirror_count && mirror_entries[slot] < key) slot++;
            for (int k = mirror_count; k > slot; k--) mirror_entries[k] = mirror_entries[k-1];
            mirror_entries[slot] = key;
            mirror_count++;
            res = '{STATUS_INSERTED, POS_W'(slot), FILL_W'(mirror_count)};
        end
        return res;
    endfunction

    initial begin
        in_bus.valid = 1'b0;
        in_bus.value = '0;
        out_bus.ready = 1'b0;
    end

    // stimulus
    initial begin
        logic signed [VALUE_W-1:0] pick;
        int                        sel;
        int                        directed_items;
        pending_values = '{
            32'sh0000_0000, 32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'shFFFF_FFFF, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0002, 32'shFFFF_FFFE,
            32'sh0000_0064, 32'shFFFF_FF9C, 32'sh4000_0000, 32'shC000_0000,
            32'sh7FFF_FFFE, 32'sh8000_0001, 32'sh0000_3039, 32'sh0000_0003,
            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh7FFF_FFFD
        };
        directed_items = pending_values.size();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 9);
            pick = pending_values[$urandom_range(0, directed_items - 1)];
            if (sel >= 8) begin
                pick = $urandom;
            end else if (sel >= 6) begin
                pick = (sel == 6) ? pick + 1 : pick - 1;
            end
            pending_values.push_back(pick);
        end
        total_items = pending_values.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_values.size() != 0 || in_bus.valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (awaited_results.size() != 0) mismatch_count++;
        $display("tb: %0d lookups checked: %0d found, %0d inserted, %0d rejected as full",
                 checked_results, found_seen, inserted_seen, full_seen);
        $display("tb: %0d mismatches, receiver held off %0d cycles once", mismatch_count,
                 HOLD_OFF_CYCLES);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    // long receiver stall so the block backs up into its input
    initial begin
        wait (accepted_items >= HOLD_OFF_START);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // input transaction accept and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            awaited_results.push_back(search_or_insert(in_bus.value));
            accepted_items++;
            in_taken = 1'b1;
            tail_part = (accepted_items >= total_items - TAIL_ITEMS);
        end
    end

    // driver
    always @(negedge i_clk) begin
        logic                      next_valid;
        logic signed [VALUE_W-1:0] next_value;
        next_valid = in_bus.valid;
        next_value = in_bus.value;
        if (i_rst_n && (!in_bus.valid || in_taken)) begin
            in_taken = 1'b0;
            next_valid = 1'b0;
            if (tx_gap_left > 0) begin
                tx_gap_left--;
            end else if (pending_values.size() != 0) begin
                if (!tail_part && tx_calm_left == 0 && $urandom_range(0, 5) == 0) begin
                    tx_gap_left = $urandom_range(1, 11) - 1;
                end else begin
                    if (tx_calm_left > 0) begin
                        tx_calm_left--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        tx_calm_left = $urandom_range(20, 60);
                    end
                    next_valid = 1'b1;
                    next_value = pending_values.pop_front();
                end
            end
        end
        in_bus.valid <= next_valid;
        in_bus.value <= next_value;
    end

    // result ready
    always @(negedge i_clk) begin
        logic next_ready;
        next_ready = 1'b0;
        if (i_rst_n && !hold_off) begin
            if (rx_gap_left > 0) begin
                rx_gap_left--;
            end else if (tail_part || rx_calm_left > 0) begin
                if (rx_calm_left > 0) rx_calm_left--;
                next_ready = 1'b1;
            end else if ($urandom_range(0, 149) == 0) begin
                rx_calm_left = $urandom_range(50, 200);
                next_ready = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                rx_gap_left = $urandom_range(1, 11) - 1;
            end else begin
                next_ready = 1'b1;
            end
        end
        out_bus.ready <= next_ready;
    end

    // result check
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("tb: unexpected result status=%0d position=%0d filled=%0d",
                             out_bus.status, out_bus.position, out_bus.filled_after);
            end else begin
                want = awaited_results.pop_front();
                checked_results++;
                case (want.status)
                    STATUS_FOUND:    found_seen++;
                    STATUS_INSERTED: inserted_seen++;
                    default:         full_seen++;
                endcase
                if (out_bus.status !== want.status || out_bus.position !== want.position ||
                    out_bus.filled_after !== want.filled_after) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("tb: result %0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 checked_results, want.status, want.position,
                                 want.filled_after, out_bus.status, out_bus.position,
                                 out_bus.filled_after);
                end
            end
        end
    end

endmodule
